@@ rtl/tkc_pkg.sv @@
// shared types, constants and codes for the tile key lru cache
`default_nettype none
package tkc_pkg;

  localparam int ENTRIES     = 128;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int STAMP_W     = 32;
  localparam int KEY_W       = 45;
  localparam int CFG_W       = 8;
  localparam int CAPACITY_RESET = 100;

  // register indexes
  localparam logic [0:0] CFG_FETCH_ENABLE = 1'b0;
  localparam logic [0:0] CFG_CAPACITY     = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_EVICTED  = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  localparam logic MODE_LOOKUP = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [4:0]  zoom;
    logic [19:0] tile_x;
    logic [19:0] tile_y;
    logic [15:0] payload_handle;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_handle;
    logic [15:0] evicted_handle;
  } out_res_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
    logic [STAMP_W-1:0]     stamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/tkc_ram.sv @@
// generic single write port ram with one registered read port
`default_nettype none
module tkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/tkc_datapath.sv @@
// entry store, scan trackers, configuration and result register
`default_nettype none
module tkc_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tkc_pkg::in_req_t    in_data,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [tkc_pkg::CFG_W-1:0] cfg_wdata,
  input  wire tkc_pkg::ctrl_cmd_t  cmd,
  output tkc_pkg::dp_status_t      sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tkc_pkg::out_res_t        out_data
);

  localparam int IW = tkc_pkg::IDX_W;
  localparam int CW = tkc_pkg::CNT_W;
  localparam int HB = tkc_pkg::HANDLE_BITS;
  localparam int SW = tkc_pkg::STAMP_W;

  // request and configuration
  tkc_pkg::in_req_t req_r;
  logic             fetch_en_r;
  logic [CW-1:0]    cap_r;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [SW-1:0]    ctr_r, ctr_nxt;
  logic [tkc_pkg::ENTRIES-1:0] valid_r;

  // scan pipeline
  logic [IW-1:0]    scan_idx_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic             rd_ev_r;
  tkc_pkg::entry_t  rd_entry;

  // trackers
  logic             hit_r;
  logic [IW-1:0]    hit_idx_r;
  logic [HB-1:0]    hit_handle_r;
  logic             old_r;
  logic [IW-1:0]    old_idx_r;
  logic [HB-1:0]    old_handle_r;
  logic [SW-1:0]    old_stamp_r;
  logic             free_r;
  logic [IW-1:0]    free_idx_r;

  // output register
  logic              out_valid_r;
  tkc_pkg::out_res_t out_data_r;

  // resolve outcome
  tkc_pkg::out_res_t res;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  tkc_pkg::entry_t   wr_entry;
  logic              bump_ctr;
  logic              bump_fill;
  logic [tkc_pkg::KEY_W-1:0] req_key;

  assign req_key = {req_r.zoom, req_r.tile_x, req_r.tile_y};

  tkc_ram #(
    .WIDTH($bits(tkc_pkg::entry_t)),
    .DEPTH(tkc_pkg::ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en && cmd.commit),
    .waddr (wr_idx),
    .wdata (wr_entry),
    .raddr (scan_idx_r),
    .rdata (rd_entry)
  );

  always_comb begin
    res       = '0;
    wr_en     = 1'b0;
    wr_idx    = hit_idx_r;
    bump_ctr  = 1'b0;
    bump_fill = 1'b0;
    wr_entry.key    = req_key;
    wr_entry.handle = HB'(req_r.payload_handle);
    wr_entry.stamp  = ctr_r;
    if (req_r.mode == tkc_pkg::MODE_LOOKUP) begin
      if (hit_r) begin
        res.status       = tkc_pkg::ST_HIT;
        res.found_handle = 16'(hit_handle_r);
        wr_en            = 1'b1;
        wr_entry.handle  = hit_handle_r;
        bump_ctr         = 1'b1;
      end else begin
        res.status = tkc_pkg::ST_MISS;
      end
    end else if (!fetch_en_r) begin
      res.status = tkc_pkg::ST_IGNORED;
    end else if (hit_r) begin
      res.status       = tkc_pkg::ST_HIT;
      res.found_handle = 16'(hit_handle_r);
    end else begin
      wr_en    = 1'b1;
      bump_ctr = 1'b1;
      if (fill_r >= cap_r && old_r) begin
        wr_idx             = old_idx_r;
        res.status         = tkc_pkg::ST_EVICTED;
        res.evicted_handle = 16'(old_handle_r);
      end else if (free_r) begin
        wr_idx     = free_idx_r;
        res.status = tkc_pkg::ST_INSERTED;
        bump_fill  = 1'b1;
      end else begin
        // store full with no free slot
        wr_idx             = old_r ? old_idx_r : '0;
        res.status         = tkc_pkg::ST_EVICTED;
        res.evicted_handle = 16'(old_handle_r);
      end
    end
  end

  assign ctr_nxt  = ctr_r + SW'(1);
  assign fill_nxt = fill_r + CW'(1);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_en_r  <= 1'b0;
      cap_r       <= CW'(tkc_pkg::CAPACITY_RESET);
      fill_r      <= '0;
      ctr_r       <= '0;
      valid_r     <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tkc_pkg::CFG_FETCH_ENABLE: fetch_en_r <= cfg_wdata[0];
          tkc_pkg::CFG_CAPACITY: begin
            if (fill_r == '0) begin
              if (cfg_wdata == '0) begin
                cap_r <= CW'(1);
              end else if (int'(cfg_wdata) > tkc_pkg::ENTRIES) begin
                cap_r <= CW'(tkc_pkg::ENTRIES);
              end else begin
                cap_r <= CW'(cfg_wdata);
              end
            end
          end
          default: ;
        endcase
      end
      rd_vld_r <= cmd.scan_rd;
      if (cmd.start) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + IW'(1);
      end
      if (cmd.commit) begin
        if (wr_en) begin
          valid_r[wr_idx] <= 1'b1;
        end
        if (bump_ctr) begin
          ctr_r <= ctr_nxt;
        end
        if (bump_fill) begin
          fill_r <= fill_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and trackers
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    rd_ev_r  <= valid_r[scan_idx_r];
    if (cmd.start) begin
      req_r  <= in_data;
      hit_r  <= 1'b0;
      old_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_ev_r) begin
        if (!hit_r && rd_entry.key == req_key) begin
          hit_r        <= 1'b1;
          hit_idx_r    <= rd_idx_r;
          hit_handle_r <= rd_entry.handle;
        end
        // strict compare keeps the lowest index on a tie
        if (!old_r || rd_entry.stamp < old_stamp_r) begin
          old_r        <= 1'b1;
          old_idx_r    <= rd_idx_r;
          old_handle_r <= rd_entry.handle;
          old_stamp_r  <= rd_entry.stamp;
        end
      end else if (!free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign sts.scan_last = (scan_idx_r == IW'(tkc_pkg::ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule
`default_nettype wire

@@ rtl/tkc_ctrl.sv @@
// request sequencer: accept, scan the entries, resolve and hand off
`default_nettype none
module tkc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tkc_pkg::dp_status_t sts,
  output tkc_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_LAST    = 2'd2;
  localparam logic [1:0] S_RESOLVE = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.start   = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      // last read data lands in the trackers
      S_LAST: state_nxt = S_RESOLVE;
      S_RESOLVE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/tile_key_lru_cache_core.sv @@
// top level of the fully associative tile cache with lru replacement
//
//   channel | ports                           | carries
//   --------+---------------------------------+------------------------------
//   in      | in_valid, in_stall, in_data     | lookup or insert request
//   out     | out_valid, out_stall, out_data  | status and handles, one each
//   cfg     | cfg_we, cfg_index, cfg_wdata    | fetch enable, capacity limit
//
// a request is accepted, then the entry ram is scanned entry by entry through
// its single read port, the last read lands in the trackers, and then the
// result is resolved and written back.
// reset clears the valid bits, the use counter and the fill count at once.
// a result waiting on out_stall holds the resolve step; the next request
// is taken as soon as the result is in the output register.
`default_nettype none
module tile_key_lru_cache_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire tkc_pkg::in_req_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output tkc_pkg::out_res_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [tkc_pkg::CFG_W-1:0] cfg_wdata
);

  tkc_pkg::ctrl_cmd_t  cmd;
  tkc_pkg::dp_status_t sts;

  tkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tkc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
